// File: sv/ccl_pkg.sv
// Shared types, constants and codes of the controller learn mapper.
package ccl_pkg;

   // Table geometry
   localparam int unsigned CC_COUNT    = 128;
   localparam int unsigned CC_W        = $clog2(CC_COUNT);
   localparam int unsigned BANK_SIZE   = 64;
   localparam int unsigned BANK_W      = $clog2(BANK_SIZE);
   localparam int unsigned PARAM_COUNT = 64;
   localparam int unsigned PARAM_W     = 6;
   localparam int unsigned VALUE_W     = 7;

   // Command codes carried on the request tuser
   typedef enum logic [2:0] {
      CMD_EVENT       = 3'd0,
      CMD_ARM         = 3'd1,
      CMD_CANCEL      = 3'd2,
      CMD_CLEAR_PARAM = 3'd3,
      CMD_CLEAR_ALL   = 3'd4,
      CMD_FLUSH       = 3'd5,
      CMD_QUERY       = 3'd6,
      CMD_RSVD        = 3'd7
   } cmd_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_BIND,
      ST_FIN
   } state_type;

   // One request transaction
   typedef struct packed {
      cmd_type              command;
      logic [CC_W-1:0]      cc_number;
      logic [VALUE_W-1:0]   cc_value;
      logic [PARAM_W-1:0]   param_index;
      logic                 flush_bank;
   } item_type;

   // One response transaction
   typedef struct packed {
      logic                 update_valid;
      logic [PARAM_W-1:0]   update_param;
      logic [VALUE_W-1:0]   update_value;
      logic                 last;
      logic                 learned;
      logic                 armed;
      logic [PARAM_W-1:0]   armed_param;
      logic                 found;
      logic [CC_W-1:0]      found_cc;
   } result_type;

   // Load request from the sequencer into the response register
   typedef struct packed {
      logic                 load;
      result_type           data;
   } rsp_load_type;

endpackage

// File: sv/midi_cc_learn_mapper.sv
// Top level of the controller learn mapper: RAMs, sequencer and response register.
// Sequence: a controller event with nothing armed passes EXEC, BIND and FIN;
// learn sweeps all 128 bindings at one entry a cycle, as do clear param and query.
// A flush sweeps its 64-controller bank, stalling while an update waits for the output.
// Throughput: one transaction at a time; the binding RAM sweep sets the rate.
// Reset: synchronous; valid bits and the armed slot clear at once, no clearing pass.
module midi_cc_learn_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cc_number[6:0], cc_value[13:7], param_index[19:14], flush_bank[20], zero[23:21]
   input  logic [23:0] req_tdata,
   // command[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // update_param[5:0], update_value[12:6], learned[13], armed[14],
   // armed_param[20:15], found[21], found_cc[28:22], zero[31:29]
   output logic [31:0] rsp_tdata,
   // update_valid[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   ccl_pkg::item_type                req_item;
   logic [ccl_pkg::CC_W-1:0]         rd_addr;
   logic [ccl_pkg::CC_W-1:0]         wr_addr;
   logic [ccl_pkg::PARAM_W-1:0]      bind_rd;
   logic [ccl_pkg::VALUE_W-1:0]      pend_rd;
   logic                             bind_we;
   logic [ccl_pkg::PARAM_W-1:0]      bind_wdata;
   logic                             pend_we;
   logic [ccl_pkg::VALUE_W-1:0]      pend_wdata;
   logic                             out_free;
   ccl_pkg::rsp_load_type            rsp_load;
   ccl_pkg::result_type              rsp_ff;
   logic                             rsp_vld_ff, rsp_vld_in;

   // Unpack the request transaction
   assign req_item.command     = ccl_pkg::cmd_type'(req_tuser);
   assign req_item.cc_number   = req_tdata[6:0];
   assign req_item.cc_value    = req_tdata[13:7];
   assign req_item.param_index = req_tdata[19:14];
   assign req_item.flush_bank  = req_tdata[20];

   ccl_ram #(
      .WIDTH (ccl_pkg::PARAM_W),
      .DEPTH (ccl_pkg::CC_COUNT)
   ) u_bind_ram (
      .clock   (clock),
      .wr_en   (bind_we),
      .wr_addr (wr_addr),
      .wr_data (bind_wdata),
      .rd_addr (rd_addr),
      .rd_data (bind_rd)
   );

   ccl_ram #(
      .WIDTH (ccl_pkg::VALUE_W),
      .DEPTH (ccl_pkg::CC_COUNT)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (wr_addr),
      .wr_data (pend_wdata),
      .rd_addr (rd_addr),
      .rd_data (pend_rd)
   );

   ccl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .rd_addr    (rd_addr),
      .bind_rd    (bind_rd),
      .pend_rd    (pend_rd),
      .bind_we    (bind_we),
      .bind_wdata (bind_wdata),
      .pend_we    (pend_we),
      .pend_wdata (pend_wdata),
      .wr_addr    (wr_addr),
      .out_free   (out_free),
      .rsp_load   (rsp_load)
   );

   // Response register: free when empty or being taken
   assign out_free = !rsp_vld_ff || rsp_tready;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load.load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         rsp_ff <= rsp_load.data;
      end
   end

   // Pack the response transaction
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.update_valid;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {3'b000, rsp_ff.found_cc, rsp_ff.found, rsp_ff.armed_param,
                        rsp_ff.armed, rsp_ff.learned, rsp_ff.update_value,
                        rsp_ff.update_param};

endmodule

// File: sv/ccl_ram.sv
// Single-port-write, single-port-read RAM with a registered read.
module ccl_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 128,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ccl_ctrl.sv
// Sequencer: valid bits, learn state and table sweeps over the binding and pending RAMs.
module ccl_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ccl_pkg::item_type             req_item,
   output logic [ccl_pkg::CC_W-1:0]      rd_addr,
   input  logic [ccl_pkg::PARAM_W-1:0]   bind_rd,
   input  logic [ccl_pkg::VALUE_W-1:0]   pend_rd,
   output logic                          bind_we,
   output logic [ccl_pkg::PARAM_W-1:0]   bind_wdata,
   output logic                          pend_we,
   output logic [ccl_pkg::VALUE_W-1:0]   pend_wdata,
   output logic [ccl_pkg::CC_W-1:0]      wr_addr,
   input  logic                          out_free,
   output ccl_pkg::rsp_load_type         rsp_load
);

   ccl_pkg::state_type               state_ff, state_in;
   ccl_pkg::item_type                item_ff, item_in;
   logic [ccl_pkg::CC_W-1:0]         idx_ff, idx_in;
   logic [ccl_pkg::CC_W-1:0]         end_ff, end_in;
   logic [ccl_pkg::PARAM_W-1:0]      key_ff, key_in;
   logic [ccl_pkg::CC_COUNT-1:0]     bind_vld_ff, bind_vld_in;
   logic [ccl_pkg::CC_COUNT-1:0]     pend_vld_ff, pend_vld_in;
   logic                             arm_ok_ff, arm_ok_in;
   logic [ccl_pkg::PARAM_W-1:0]      arm_par_ff, arm_par_in;
   logic                             learned_ff, learned_in;
   logic                             found_ff, found_in;
   logic [ccl_pkg::CC_W-1:0]         fcc_ff, fcc_in;
   logic                             hold_vld_ff, hold_vld_in;
   logic [ccl_pkg::PARAM_W-1:0]      hold_par_ff, hold_par_in;
   logic [ccl_pkg::VALUE_W-1:0]      hold_val_ff, hold_val_in;

   logic                             p_ok;
   logic                             hit;
   logic                             flush_emit;
   logic                             sweep_stall;
   logic                             sweep_done;
   logic [ccl_pkg::PARAM_W-1:0]      armed_par_vis;
   logic [ccl_pkg::CC_W-1:0]         bank_start;

   // Decode helpers
   assign p_ok = 32'(item_ff.param_index) < ccl_pkg::PARAM_COUNT;
   assign hit = bind_vld_ff[idx_ff] && (bind_rd == key_ff);
   assign flush_emit = (item_ff.command == ccl_pkg::CMD_FLUSH) &&
                       pend_vld_ff[idx_ff] && bind_vld_ff[idx_ff];
   assign sweep_stall = (state_ff == ccl_pkg::ST_SWEEP) && flush_emit &&
                        hold_vld_ff && !out_free;
   assign sweep_done = !sweep_stall && (idx_ff == end_ff);
   assign armed_par_vis = arm_ok_ff ? arm_par_ff : '0;
   assign bank_start = ccl_pkg::CC_W'(item_ff.flush_bank) << ccl_pkg::BANK_W;

   assign req_ready  = (state_ff == ccl_pkg::ST_IDLE);
   assign rd_addr    = idx_in;
   assign wr_addr    = item_ff.cc_number;
   assign bind_wdata = arm_par_ff;
   assign pend_wdata = item_ff.cc_value;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ccl_pkg::ST_EXEC;
            end
         end
         ccl_pkg::ST_EXEC: begin
            unique case (item_ff.command)
               ccl_pkg::CMD_EVENT: begin
                  state_in = arm_ok_ff ? ccl_pkg::ST_SWEEP : ccl_pkg::ST_BIND;
               end
               ccl_pkg::CMD_CLEAR_PARAM, ccl_pkg::CMD_QUERY: begin
                  state_in = p_ok ? ccl_pkg::ST_SWEEP : ccl_pkg::ST_FIN;
               end
               ccl_pkg::CMD_FLUSH: begin
                  state_in = ccl_pkg::ST_SWEEP;
               end
               default: begin
                  state_in = ccl_pkg::ST_FIN;
               end
            endcase
         end
         ccl_pkg::ST_SWEEP: begin
            if (sweep_done) begin
               state_in = (item_ff.command == ccl_pkg::CMD_EVENT) ?
                          ccl_pkg::ST_BIND : ccl_pkg::ST_FIN;
            end
         end
         ccl_pkg::ST_BIND: begin
            state_in = ccl_pkg::ST_FIN;
         end
         ccl_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = ccl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ccl_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM controls and response loads
   always_comb begin
      item_in     = item_ff;
      idx_in      = idx_ff;
      end_in      = end_ff;
      key_in      = key_ff;
      bind_vld_in = bind_vld_ff;
      pend_vld_in = pend_vld_ff;
      arm_ok_in   = arm_ok_ff;
      arm_par_in  = arm_par_ff;
      learned_in  = learned_ff;
      found_in    = found_ff;
      fcc_in      = fcc_ff;
      hold_vld_in = hold_vld_ff;
      hold_par_in = hold_par_ff;
      hold_val_in = hold_val_ff;
      bind_we     = 1'b0;
      pend_we     = 1'b0;
      rsp_load    = '0;
      rsp_load.data.armed       = arm_ok_ff;
      rsp_load.data.armed_param = armed_par_vis;

      unique case (state_ff)
         ccl_pkg::ST_IDLE: begin
            // Capture the transaction and clear per-item flags
            if (req_valid) begin
               item_in    = req_item;
               learned_in = 1'b0;
               found_in   = 1'b0;
               fcc_in     = '0;
            end
         end
         ccl_pkg::ST_EXEC: begin
            unique case (item_ff.command)
               ccl_pkg::CMD_EVENT: begin
                  key_in = arm_par_ff;
                  idx_in = '0;
                  end_in = '1;
               end
               ccl_pkg::CMD_ARM: begin
                  arm_ok_in  = p_ok;
                  arm_par_in = p_ok ? item_ff.param_index : '0;
               end
               ccl_pkg::CMD_CANCEL: begin
                  arm_ok_in  = 1'b0;
                  arm_par_in = '0;
               end
               ccl_pkg::CMD_CLEAR_PARAM, ccl_pkg::CMD_QUERY: begin
                  key_in = item_ff.param_index;
                  idx_in = '0;
                  end_in = '1;
               end
               ccl_pkg::CMD_CLEAR_ALL: begin
                  bind_vld_in = '0;
               end
               ccl_pkg::CMD_FLUSH: begin
                  idx_in = bank_start;
                  end_in = bank_start | ccl_pkg::CC_W'(ccl_pkg::BANK_SIZE - 1);
               end
               default: begin
               end
            endcase
         end
         ccl_pkg::ST_SWEEP: begin
            // Evaluate the entry whose RAM data is present now
            unique case (item_ff.command)
               ccl_pkg::CMD_QUERY: begin
                  if (hit && !found_ff) begin
                     found_in = 1'b1;
                     fcc_in   = idx_ff;
                  end
               end
               ccl_pkg::CMD_FLUSH: begin
                  if (!sweep_stall && pend_vld_ff[idx_ff]) begin
                     pend_vld_in[idx_ff] = 1'b0;
                     if (bind_vld_ff[idx_ff]) begin
                        // Push the held update out, keep the new one back
                        if (hold_vld_ff) begin
                           rsp_load.load              = 1'b1;
                           rsp_load.data.update_valid = 1'b1;
                           rsp_load.data.update_param = hold_par_ff;
                           rsp_load.data.update_value = hold_val_ff;
                        end
                        hold_vld_in = 1'b1;
                        hold_par_in = bind_rd;
                        hold_val_in = pend_rd;
                     end
                  end
               end
               default: begin
                  // Unbind on learn and clear param
                  if (hit) begin
                     bind_vld_in[idx_ff] = 1'b0;
                  end
               end
            endcase
            // Advance unless the response side is full
            if (!sweep_stall) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ccl_pkg::ST_BIND: begin
            // Bind the armed parameter, then store the value if mapped
            if (arm_ok_ff) begin
               bind_vld_in[item_ff.cc_number] = 1'b1;
               bind_we    = 1'b1;
               arm_ok_in  = 1'b0;
               learned_in = 1'b1;
            end
            if (arm_ok_ff || bind_vld_ff[item_ff.cc_number]) begin
               pend_vld_in[item_ff.cc_number] = 1'b1;
               pend_we = 1'b1;
            end
         end
         ccl_pkg::ST_FIN: begin
            // Send the closing transaction
            if (out_free) begin
               rsp_load.load      = 1'b1;
               rsp_load.data.last = 1'b1;
               if (hold_vld_ff) begin
                  rsp_load.data.update_valid = 1'b1;
                  rsp_load.data.update_param = hold_par_ff;
                  rsp_load.data.update_value = hold_val_ff;
                  hold_vld_in = 1'b0;
               end else begin
                  rsp_load.data.learned  = learned_ff;
                  rsp_load.data.found    = found_ff;
                  rsp_load.data.found_cc = fcc_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ccl_pkg::ST_IDLE;
         bind_vld_ff <= '0;
         pend_vld_ff <= '0;
         arm_ok_ff   <= 1'b0;
         arm_par_ff  <= '0;
         hold_vld_ff <= 1'b0;
         learned_ff  <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         bind_vld_ff <= bind_vld_in;
         pend_vld_ff <= pend_vld_in;
         arm_ok_ff   <= arm_ok_in;
         arm_par_ff  <= arm_par_in;
         hold_vld_ff <= hold_vld_in;
         learned_ff  <= learned_in;
         found_ff    <= found_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      key_ff      <= key_in;
      fcc_ff      <= fcc_in;
      hold_par_ff <= hold_par_in;
      hold_val_ff <= hold_val_in;
   end

`ifndef SYNTHESIS
   a_hold_empty_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ccl_pkg::ST_IDLE |-> !hold_vld_ff)
      else $error("held update left over between transactions");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load.load |-> out_free)
      else $error("response loaded while output register busy");

   a_learn_disarms: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ccl_pkg::ST_BIND && arm_ok_ff) |=> (!arm_ok_ff && learned_ff))
      else $error("learn did not disarm");

   a_flush_in_bank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ccl_pkg::ST_SWEEP && item_ff.command == ccl_pkg::CMD_FLUSH)
      |-> (idx_ff[ccl_pkg::CC_W-1] == item_ff.flush_bank))
      else $error("flush sweep left its bank");
`endif

endmodule

// File: dv/tb_midi_cc_learn_mapper.sv
// Self-checking stream testbench for the controller learn mapper: directed and random commands.
module tb_midi_cc_learn_mapper;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int ITEM_TARGET   = 430;
   localparam int STALL_LIMIT   = 4000;
   localparam int TAIL_CYCLES   = 200;
   localparam int REPORT_LIMIT  = 10;
   localparam int CALM_FIRST    = 180;
   localparam int CALM_LAST     = 260;
   localparam int POOL_SIZE     = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   midi_cc_learn_mapper u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   // Commands waiting to be sent; a set hold flag makes the sender drain first
   ccl_pkg::item_type   cmd_queue[$];
   bit                  drain_first[$];
   // Responses the mapper still owes, oldest first
   ccl_pkg::result_type owed_results[$];

   // Mirror of the mapper state
   bit                          map_valid  [ccl_pkg::CC_COUNT];
   logic [ccl_pkg::PARAM_W-1:0] map_param  [ccl_pkg::CC_COUNT];
   bit                          held_valid [ccl_pkg::CC_COUNT];
   logic [ccl_pkg::VALUE_W-1:0] held_value [ccl_pkg::CC_COUNT];
   bit                          learn_armed;
   logic [ccl_pkg::PARAM_W-1:0] learn_param;

   ccl_pkg::item_type        live_item;
   int                       sent_count;
   logic                     calm_stretch = 1'b0;
   int                       fault_count;
   int                       quiet_cycles;
   logic [ccl_pkg::CC_W-1:0] cc_pool[POOL_SIZE];

   // Unbind a parameter from every controller
   task automatic drop_bindings_of(input logic [ccl_pkg::PARAM_W-1:0] par);
      for (int c = 0; c < ccl_pkg::CC_COUNT; c++)
         if (map_valid[c] && map_param[c] == par)
            map_valid[c] = 1'b0;
   endtask

   // Advance the mirror by one command and queue the responses it causes
   task automatic apply_mapper_cmd(input ccl_pkg::item_type it);
      ccl_pkg::result_type batch[$];
      ccl_pkg::result_type stat;
      ccl_pkg::result_type upd;
      int                  base;
      stat = '0;
      case (it.command)
         ccl_pkg::CMD_EVENT: begin
            if (learn_armed) begin
               drop_bindings_of(learn_param);
               map_valid[it.cc_number] = 1'b1;
               map_param[it.cc_number] = learn_param;
               learn_armed = 1'b0;
               learn_param = '0;
               stat.learned = 1'b1;
            end
            if (map_valid[it.cc_number]) begin
               held_valid[it.cc_number] = 1'b1;
               held_value[it.cc_number] = it.cc_value;
            end
         end
         ccl_pkg::CMD_ARM: begin
            learn_armed = (it.param_index < ccl_pkg::PARAM_COUNT);
            learn_param = learn_armed ? it.param_index : '0;
         end
         ccl_pkg::CMD_CANCEL: begin
            learn_armed = 1'b0;
            learn_param = '0;
         end
         ccl_pkg::CMD_CLEAR_PARAM: begin
            if (it.param_index < ccl_pkg::PARAM_COUNT)
               drop_bindings_of(it.param_index);
         end
         ccl_pkg::CMD_CLEAR_ALL: begin
            foreach (map_valid[c]) map_valid[c] = 1'b0;
         end
         ccl_pkg::CMD_FLUSH: begin
            base = it.flush_bank ? ccl_pkg::BANK_SIZE : 0;
            // Consume the bank's pending values; only mapped controllers emit
            for (int c = base; c < base + ccl_pkg::BANK_SIZE; c++) begin
               if (held_valid[c]) begin
                  held_valid[c] = 1'b0;
                  if (map_valid[c]) begin
                     upd = '0;
                     upd.update_valid = 1'b1;
                     upd.update_param = map_param[c];
                     upd.update_value = held_value[c];
                     batch.insert(batch.size(), upd);
                  end
               end
            end
         end
         ccl_pkg::CMD_QUERY: begin
            // Walk downward so the lowest bound controller wins
            if (it.param_index < ccl_pkg::PARAM_COUNT)
               for (int c = ccl_pkg::CC_COUNT - 1; c >= 0; c--)
                  if (map_valid[c] && map_param[c] == it.param_index) begin
                     stat.found = 1'b1;
                     stat.found_cc = c[ccl_pkg::CC_W-1:0];
                  end
         end
         default: ;
      endcase
      if (batch.size() == 0)
         batch.insert(0, stat);
      foreach (batch[k]) begin
         batch[k].armed = learn_armed;
         batch[k].armed_param = learn_armed ? learn_param : '0;
      end
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) owed_results.insert(owed_results.size(), batch[k]);
   endtask

   task automatic add_cmd(input logic [2:0] cmd, input int cc, input int val, input int par,
                          input int bank, input bit hold);
      ccl_pkg::item_type it;
      it.command     = ccl_pkg::cmd_type'(cmd);
      it.cc_number   = cc[ccl_pkg::CC_W-1:0];
      it.cc_value    = val[ccl_pkg::VALUE_W-1:0];
      it.param_index = par[ccl_pkg::PARAM_W-1:0];
      it.flush_bank  = bank[0];
      cmd_queue.insert(cmd_queue.size(), it);
      drain_first.insert(drain_first.size(), hold);
   endtask

   task automatic note_mismatch(input string field, input int want, input int got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("mismatch on %s: expected %0d, got %0d", field, want, got);
   endtask

   // Driver: predict on each accepted transaction, then present the next command
   always @(posedge clock) begin : driver
      ccl_pkg::item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_mapper_cmd(live_item);
            sent_count++;
         end
         calm_stretch <= (sent_count >= CALM_FIRST && sent_count < CALM_LAST);
         if (req_tvalid && !req_tready) begin
            // hold the presented transaction
         end else if (cmd_queue.size() > 0
                      && !(drain_first[0] && owed_results.size() > 0)
                      && !(!calm_stretch && $urandom_range(0, 99) < 11)) begin
            nxt = cmd_queue.pop_front();
            void'(drain_first.pop_front());
            live_item = nxt;
            req_tdata <= {3'b000, nxt.flush_bank, nxt.param_index, nxt.cc_value,
                          nxt.cc_number};
            req_tuser <= nxt.command;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side: random backpressure and field-by-field compare
   always @(posedge clock) begin : monitor
      ccl_pkg::result_type got;
      ccl_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm_stretch || ($urandom_range(0, 99) >= 11);
         if (rsp_tvalid && rsp_tready) begin
            got.update_valid = rsp_tuser;
            got.update_param = rsp_tdata[5:0];
            got.update_value = rsp_tdata[12:6];
            got.last         = rsp_tlast;
            got.learned      = rsp_tdata[13];
            got.armed        = rsp_tdata[14];
            got.armed_param  = rsp_tdata[20:15];
            got.found        = rsp_tdata[21];
            got.found_cc     = rsp_tdata[28:22];
            if (owed_results.size() == 0) begin
               note_mismatch("unexpected response", 0, 1);
            end else begin
               want = owed_results.pop_front();
               if (got.update_valid !== want.update_valid)
                  note_mismatch("update_valid", want.update_valid, got.update_valid);
               if (got.update_param !== want.update_param)
                  note_mismatch("update_param", want.update_param, got.update_param);
               if (got.update_value !== want.update_value)
                  note_mismatch("update_value", want.update_value, got.update_value);
               if (got.last !== want.last)
                  note_mismatch("last", want.last, got.last);
               if (got.learned !== want.learned)
                  note_mismatch("learned", want.learned, got.learned);
               if (got.armed !== want.armed)
                  note_mismatch("armed", want.armed, got.armed);
               if (got.armed_param !== want.armed_param)
                  note_mismatch("armed_param", want.armed_param, got.armed_param);
               if (got.found !== want.found)
                  note_mismatch("found", want.found, got.found);
               if (got.found_cc !== want.found_cc)
                  note_mismatch("found_cc", want.found_cc, got.found_cc);
            end
         end
      end
   end

   // Count cycles in which neither side moves a transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : stimulus
      int pick;
      int cc;
      int par;
      bit hold;
      // Directed: empty table, learn at both ends, rebind, coalesce, flush, clear
      add_cmd(ccl_pkg::CMD_QUERY, 5, 9, 0, 1, 0);
      add_cmd(ccl_pkg::CMD_FLUSH, 0, 0, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_ARM, 0, 0, 63, 0, 0);
      add_cmd(ccl_pkg::CMD_EVENT, 127, 127, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_ARM, 0, 0, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_EVENT, 0, 127, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_ARM, 0, 0, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_EVENT, 64, 85, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_EVENT, 0, 42, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_QUERY, 0, 0, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_QUERY, 0, 0, 63, 0, 0);
      add_cmd(ccl_pkg::CMD_EVENT, 127, 1, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_EVENT, 127, 2, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_FLUSH, 0, 0, 0, 1, 0);
      add_cmd(ccl_pkg::CMD_ARM, 0, 0, 42, 0, 1);
      add_cmd(ccl_pkg::CMD_CANCEL, 0, 0, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_EVENT, 10, 85, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_ARM, 0, 0, 5, 0, 0);
      add_cmd(ccl_pkg::CMD_EVENT, 10, 42, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_CLEAR_PARAM, 0, 0, 5, 0, 0);
      add_cmd(ccl_pkg::CMD_FLUSH, 0, 0, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_RSVD, 127, 127, 63, 1, 0);
      add_cmd(ccl_pkg::CMD_ARM, 0, 0, 21, 0, 0);
      add_cmd(ccl_pkg::CMD_CLEAR_ALL, 0, 0, 0, 0, 0);
      add_cmd(ccl_pkg::CMD_QUERY, 0, 0, 63, 0, 0);

      // Favorite controllers, half in each bank, so flushes find work
      for (int i = 0; i < POOL_SIZE; i++)
         cc_pool[i] = (i < POOL_SIZE / 2) ? ccl_pkg::CC_W'($urandom_range(0, 63))
                                          : ccl_pkg::CC_W'($urandom_range(64, 127));

      // Random: mostly learn pairs and events on favorites, plus noise
      while (cmd_queue.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         hold = ($urandom_range(0, 99) < 3);
         cc   = ($urandom_range(0, 99) < 70) ? cc_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : $urandom_range(0, 127);
         par  = $urandom_range(0, 63);
         if (pick < 45) begin
            add_cmd(ccl_pkg::CMD_EVENT, cc, $urandom_range(0, 127), $urandom_range(0, 63),
                    $urandom_range(0, 1), hold);
         end else if (pick < 58) begin
            add_cmd(ccl_pkg::CMD_ARM, $urandom_range(0, 127), $urandom_range(0, 127), par,
                    $urandom_range(0, 1), hold);
            if ($urandom_range(0, 99) < 75)
               add_cmd(ccl_pkg::CMD_EVENT, cc, $urandom_range(0, 127),
                       $urandom_range(0, 63), $urandom_range(0, 1), 0);
         end else if (pick < 68) begin
            add_cmd(ccl_pkg::CMD_FLUSH, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 63), $urandom_range(0, 1), hold);
         end else if (pick < 76) begin
            add_cmd(ccl_pkg::CMD_QUERY, $urandom_range(0, 127), $urandom_range(0, 127), par,
                    $urandom_range(0, 1), hold);
         end else if (pick < 81) begin
            add_cmd(ccl_pkg::CMD_CLEAR_PARAM, $urandom_range(0, 127), $urandom_range(0, 127),
                    par, $urandom_range(0, 1), hold);
         end else if (pick < 85) begin
            add_cmd(ccl_pkg::CMD_CANCEL, $urandom_range(0, 127), $urandom_range(0, 127), par,
                    $urandom_range(0, 1), hold);
         end else if (pick < 87) begin
            add_cmd(ccl_pkg::CMD_CLEAR_ALL, $urandom_range(0, 127), $urandom_range(0, 127),
                    par, $urandom_range(0, 1), hold);
         end else if (pick < 89) begin
            add_cmd(ccl_pkg::CMD_RSVD, $urandom_range(0, 127), $urandom_range(0, 127), par,
                    $urandom_range(0, 1), hold);
         end else begin
            add_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom_range(0, 127),
                    par, $urandom_range(0, 1), hold);
         end
      end

      // Release reset once
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for the queue and the owed responses to drain, or for a stall
      @(negedge clock);
      while (!(cmd_queue.size() == 0 && !req_tvalid && owed_results.size() == 0)
             && quiet_cycles < STALL_LIMIT)
         @(negedge clock);

      if (quiet_cycles >= STALL_LIMIT) begin
         $display("midi_cc_learn_mapper verification failed");
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         fault_count += owed_results.size();
         if (fault_count == 0)
            $display("midi_cc_learn_mapper verification clean");
         else
            $display("midi_cc_learn_mapper verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/ccl_pkg.sv
sv/ccl_ram.sv
sv/ccl_ctrl.sv
sv/midi_cc_learn_mapper.sv
dv/tb_midi_cc_learn_mapper.sv
